>>> hdl/otf_pkg.sv
// Package: payload types, sequencer states and fixed widths for the Otsu threshold finder.
`timescale 1ns / 1ps
package otf_pkg;

   typedef struct packed {
      logic [7:0] gray;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] threshold;
      logic       overflow;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_ACCUM,
      ST_RD,
      ST_SUMS,
      ST_PQ,
      ST_DEN,
      ST_SQ,
      ST_MUL,
      ST_CMP,
      ST_NEXT,
      ST_EMIT
   } state_type;

   // Widths of the sweep datapath, sized for the largest pixel count the block supports.
   localparam int MAX_LOG2_PIXELS = 24;
   localparam int DEN_W  = 2 * (MAX_LOG2_PIXELS + 1);
   localparam int DIFF_W = DEN_W + 8;
   localparam int PROD_W = 2 * DIFF_W + DEN_W;

endpackage

>>> hdl/otsu_threshold_finder.sv
// Otsu threshold finder: each pixel is transferred and its histogram bin read, then the bin
// is written back while req_stall is high. The pixel marked last starts a level sweep that
// holds req_stall high. Each level runs up to seven products through one shared shift-add
// multiplier. A result waits in its output register until it transfers, and the next emit
// waits behind it. After each emit, a clearing pass zeroes the histogram; the same pass runs
// after reset. Input is stalled during the sweep, the emit and the clearing pass.
`timescale 1ns / 1ps
module otsu_threshold_finder
   import otf_pkg::*;
#(
   parameter int LEVELS          = 256,
   parameter int LOG2_MAX_PIXELS = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);
   localparam int AW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW  = LOG2_MAX_PIXELS + 1;
   localparam int SW  = CW + 8;

   state_type state_ff, state_in;
   logic [AW-1:0]      lev_ff, lev_in;
   logic [CW-1:0]      n_ff, n_in, beta_ff, beta_in;
   logic [SW-1:0]      m_ff, m_in, alpha_ff, alpha_in;
   logic               drop_ff, drop_in;
   logic [DIFF_W-1:0]  bd_ff, bd_in, d_ff, d_in;
   logic [DEN_W-1:0]   bden_ff, bden_in, den_ff, den_in;
   logic [7:0]         bl_ff, bl_in;
   logic [PROD_W-1:0]  p_ff, p_in, q_ff, q_in;
   logic [2:0]         step_ff, step_in;
   logic               pend_ff, pend_in;
   logic [7:0]         tail_ff, tail_in;
   logic               rv_ff, rv_in;
   rsp_payload_type    rd_ff, rd_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [CW-1:0]      ram_wd, ram_rd;
   logic [AW-1:0]      acc_addr;
   logic               mul_start, mul_done;
   logic [PROD_W-1:0]  mul_a, mul_p;
   logic [DIFF_W-1:0]  mul_b;
   logic               req_take;

   // Bin of the pixel being written back, and whether it was counted.
   logic [AW-1:0]      waddr_ff;
   logic               wval_ff;

   otf_ram #(.WIDTH(CW), .DEPTH(1 << AW)) u_hist (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   otf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   always_comb begin
      acc_addr = (req_data.gray >= 8'(LEVELS - 1)) ? AW'(LEVELS - 1) : AW'(req_data.gray);
   end

   assign req_stall = (state_ff != ST_ACCUM) || pend_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   always_comb begin
      state_in = state_ff;
      lev_in   = lev_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      beta_in  = beta_ff;
      alpha_in = alpha_ff;
      drop_in  = drop_ff;
      bd_in    = bd_ff;
      bden_in  = bden_ff;
      bl_in    = bl_ff;
      d_in     = d_ff;
      den_in   = den_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      pend_in  = pend_ff;
      tail_in  = tail_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;
      ram_we   = 1'b0;
      ram_addr = lev_ff;
      ram_wd   = '0;
      mul_start = 1'b0;
      mul_a    = '0;
      mul_b    = '0;

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (lev_ff == AW'(LEVELS - 1)) begin
               lev_in   = '0;
               state_in = ST_ACCUM;
            end else begin
               lev_in = lev_ff + 1'b1;
            end
         end
         ST_ACCUM: begin
            // Read-modify-write: read address now, update next cycle.
            ram_addr = acc_addr;
            if (pend_ff) begin
               ram_addr = waddr_ff;
               ram_we   = wval_ff;
               ram_wd   = ram_rd + 1'b1;
               pend_in  = 1'b0;
               if (tail_ff[0]) begin
                  lev_in   = '0;
                  beta_in  = '0;
                  alpha_in = '0;
                  bd_in    = '0;
                  bden_in  = '0;
                  bl_in    = '0;
                  state_in = ST_RD;
               end
            end else if (req_take) begin
               pend_in = 1'b1;
               tail_in = {7'b0, req_data.last};
               if (n_ff >= CW'(1 << LOG2_MAX_PIXELS)) begin
                  drop_in = 1'b1;
               end else begin
                  n_in = n_ff + 1'b1;
                  m_in = m_ff + SW'(acc_addr);
               end
            end
         end
         ST_RD: state_in = ST_SUMS;
         ST_SUMS: begin
            beta_in  = beta_ff + ram_rd;
            alpha_in = alpha_ff + SW'(ram_rd) * SW'(lev_ff);
            state_in = ST_PQ;
            step_in  = '0;
         end
         ST_PQ: begin
            if (beta_ff == '0 || beta_ff >= n_ff) begin
               state_in = ST_NEXT;
            end else if (step_ff == 3'd0) begin
               mul_start = 1'b1;
               mul_a = PROD_W'(n_ff);
               mul_b = DIFF_W'(alpha_ff);
               step_in = 3'd1;
            end else if (mul_done) begin
               if (step_ff == 3'd1) begin
                  p_in = mul_p;
                  mul_start = 1'b1;
                  mul_a = PROD_W'(m_ff);
                  mul_b = DIFF_W'(beta_ff);
                  step_in = 3'd2;
               end else begin
                  d_in = (p_ff >= mul_p) ? DIFF_W'(p_ff - mul_p) : DIFF_W'(mul_p - p_ff);
                  mul_start = 1'b1;
                  mul_a = PROD_W'(beta_ff);
                  mul_b = DIFF_W'(n_ff - beta_ff);
                  state_in = ST_DEN;
               end
            end
         end
         ST_DEN: begin
            if (mul_done) begin
               den_in = DEN_W'(mul_p);
               if (bden_ff == '0) begin
                  bd_in = d_ff;
                  bden_in = DEN_W'(mul_p);
                  bl_in = 8'(lev_ff);
                  state_in = ST_NEXT;
               end else begin
                  mul_start = 1'b1;
                  mul_a = PROD_W'(d_ff);
                  mul_b = d_ff;
                  step_in = 3'd0;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            // step 0: d*d, 1: bd*bd, 2: (d*d)*bden, 3: (bd*bd)*den
            if (mul_done) begin
               unique case (step_ff)
                  3'd0: begin
                     p_in = mul_p;
                     mul_start = 1'b1;
                     mul_a = PROD_W'(bd_ff);
                     mul_b = bd_ff;
                     step_in = 3'd1;
                  end
                  3'd1: begin
                     q_in = mul_p;
                     mul_start = 1'b1;
                     mul_a = p_ff;
                     mul_b = DIFF_W'(bden_ff);
                     step_in = 3'd2;
                  end
                  3'd2: begin
                     p_in = mul_p;
                     mul_start = 1'b1;
                     mul_a = q_ff;
                     mul_b = DIFF_W'(den_ff);
                     step_in = 3'd3;
                     state_in = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               q_in = mul_p;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (p_ff > q_ff) begin
               bd_in = d_ff;
               bden_in = den_ff;
               bl_in = 8'(lev_ff);
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (lev_ff == AW'(LEVELS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               lev_in = lev_ff + 1'b1;
               ram_addr = lev_ff + 1'b1;
               state_in = ST_SUMS;
            end
         end
         ST_EMIT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rd_in.threshold = bl_ff;
               rd_in.overflow = drop_ff;
               n_in = '0;
               m_in = '0;
               drop_in = 1'b0;
               lev_in = '0;
               state_in = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         lev_ff   <= '0;
         n_ff     <= '0;
         m_ff     <= '0;
         drop_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         wval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lev_ff   <= lev_in;
         n_ff     <= n_in;
         m_ff     <= m_in;
         drop_ff  <= drop_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
         wval_ff  <= req_take && (n_ff < CW'(1 << LOG2_MAX_PIXELS));
      end
      waddr_ff <= acc_addr;
      beta_ff  <= beta_in;
      alpha_ff <= alpha_in;
      bd_ff    <= bd_in;
      bden_ff  <= bden_in;
      bl_ff    <= bl_in;
      d_ff     <= d_in;
      den_ff   <= den_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      tail_ff  <= tail_in;
      rd_ff    <= rd_in;
   end
endmodule

>>> hdl/otf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module otf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

>>> hdl/otf_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, shared by all products of the sweep.
`timescale 1ns / 1ps
module otf_mul
   import otf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] op_a,
   input  logic [DIFF_W-1:0] op_b,
   output logic              done,
   output logic [PROD_W-1:0] product
);
   logic [PROD_W-1:0]         acc_ff, acc_in;
   logic [PROD_W-1:0]         a_ff, a_in;
   logic [DIFF_W-1:0]         b_ff, b_in;
   logic                      busy_ff, busy_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      done    = busy_ff && (b_ff == '0);
      if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[PROD_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[DIFF_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign product = acc_ff;
endmodule

>>> hdl/otf_checker.sv
// Port-level checker for the Otsu threshold finder, bound to the top level.
`timescale 1ns / 1ps
module otf_checker
   import otf_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);
   // After a last pixel transfer, the input is stalled.
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("input not stalled after last pixel");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A new result appears only while the input is held off.
   a_rsp_rise_stalled: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result raised while input open");
endmodule

bind otsu_threshold_finder otf_checker u_otf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
